@@ sv/frac_red_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frac_red_pkg
// Shared value width and transaction payload types of the fraction reducer.
// ----------------------------------------------------------------------------
package frac_red_pkg;

  localparam int unsigned VALUE_WIDTH = 16;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] top_value;
    logic [VALUE_WIDTH-1:0] bottom_value;
  } frac_in_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] reduced_top;
    logic [VALUE_WIDTH-1:0] reduced_bottom;
  } frac_out_t;

endpackage

@@ sv/fraction_reducer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_reducer_core
// Reduces an unsigned fraction to lowest terms with a shared subtractor.
// ----------------------------------------------------------------------------
// One transaction is processed at a time; in_ready_o is high only while the
// core is idle. All arithmetic runs through a single VALUE_WIDTH+1 bit
// subtractor under a small sequencer. A binary gcd pass (common factors of
// two are stripped from both operands on the fly, then subtract-and-halve
// steps on the odd part) comes first, after which numerator and denominator
// are each divided by the odd part of the gcd with a restoring divider,
// numerator first, then denominator. Equal values give 1/1 (including 0/0);
// a zero numerator or denominator passes through unchanged. The result sits
// in an output register; the last divider step waits while that register
// is still full.
// ----------------------------------------------------------------------------
module fraction_reducer_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  frac_red_pkg::frac_in_t in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output frac_red_pkg::frac_out_t out_data_o
);

  localparam int unsigned W     = frac_red_pkg::VALUE_WIDTH;
  localparam int unsigned CNT_W = $clog2(W);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_GCD     = 2'd1;
  localparam logic [1:0] ST_DIV_TOP = 2'd2;
  localparam logic [1:0] ST_DIV_BOT = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [W-1:0]     a_q, a_d;       // odd part of gcd ends up here
  logic [W-1:0]     b_q, b_d;
  logic [W-1:0]     num_q, num_d;
  logic [W-1:0]     den_q, den_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  frac_red_pkg::frac_out_t out_q, out_d;

  // shared subtractor
  logic [W:0] sub_a, sub_b, sub_res;
  logic       borrow;
  logic [W-1:0] div_src;
  logic         div_bit;
  logic [W-1:0] rem_next;
  logic [W-1:0] quo_next;
  logic         last_step;
  logic         out_free;
  logic         in_fire;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign last_step   = (cnt_q == CNT_W'(W - 1));

  assign div_src = (state_q == ST_DIV_BOT) ? den_q : num_q;

  always_comb begin
    if (state_q == ST_GCD) begin
      sub_a = {1'b0, b_q};
    end else begin
      sub_a = {rem_q, div_src[W-1]};
    end
    sub_b   = {1'b0, a_q};
    sub_res = sub_a - sub_b;
    borrow  = sub_res[W];
  end

  // one restoring divide step
  always_comb begin
    div_bit = !borrow;
    if (borrow) begin
      rem_next = sub_a[W-1:0];
    end else begin
      rem_next = sub_res[W-1:0];
    end
    quo_next = {div_src[W-2:0], div_bit};
  end

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    num_d       = num_q;
    den_d       = den_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          num_d   = in_data_i.top_value;
          den_d   = in_data_i.bottom_value;
          state_d = ST_GCD;
          if (in_data_i.top_value == in_data_i.bottom_value) begin
            num_d = W'(1);
            den_d = W'(1);
            a_d   = W'(1);
            b_d   = '0;
          end else if (in_data_i.top_value == '0 || in_data_i.bottom_value == '0) begin
            a_d = W'(1);
            b_d = '0;
          end else begin
            a_d = in_data_i.top_value;
            b_d = in_data_i.bottom_value;
          end
        end
      end
      ST_GCD: begin
        if (b_q == '0) begin
          state_d = ST_DIV_TOP;
          rem_d   = '0;
          cnt_d   = '0;
        end else if (!a_q[0] && !b_q[0]) begin
          // common factor of two: strip it from the fraction too
          a_d   = a_q >> 1;
          b_d   = b_q >> 1;
          num_d = num_q >> 1;
          den_d = den_q >> 1;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (borrow) begin
          a_d = b_q;
          b_d = a_q;
        end else begin
          b_d = sub_res[W-1:0];
        end
      end
      ST_DIV_TOP: begin
        num_d = quo_next;
        rem_d = rem_next;
        cnt_d = cnt_q + CNT_W'(1);
        if (last_step) begin
          state_d = ST_DIV_BOT;
          rem_d   = '0;
          cnt_d   = '0;
        end
      end
      ST_DIV_BOT: begin
        if (!last_step) begin
          den_d = quo_next;
          rem_d = rem_next;
          cnt_d = cnt_q + CNT_W'(1);
        end else if (out_free) begin
          den_d                = quo_next;
          out_d.reduced_top    = num_q;
          out_d.reduced_bottom = quo_next;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

endmodule
